@@ rtl/pap_pkg.sv @@
// Package for the priority aging process scheduler.
// Holds table sizes, the entry layout, result codes and FSM states.
// No dependencies.
package pap_pkg;
  localparam int unsigned MAX_PROCESSES = 16;
  localparam int unsigned IDX_W  = $clog2(MAX_PROCESSES);
  localparam int unsigned LINK_W = $clog2(MAX_PROCESSES + 1);
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_PROCESSES);

  typedef struct packed {
    logic [7:0]        pid;
    logic signed [15:0] prio;
    logic [15:0]       need;
    logic [15:0]       used;
    logic [LINK_W-1:0] next;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    EV_ADDED    = 3'd0,
    EV_REJECTED = 3'd1,
    EV_REQUEUED = 3'd2,
    EV_FINISHED = 3'd3,
    EV_IDLE     = 3'd4
  } event_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TK_RD,
    ST_INS_START,
    ST_INS_CMP,
    ST_INS_WI,
    ST_INS_WP,
    ST_WK_START,
    ST_WK_CMP,
    ST_WK_W1,
    ST_WK_W2,
    ST_BK_START,
    ST_BK_HEAD,
    ST_BK_CMP,
    ST_BK_W1,
    ST_BK_W2,
    ST_DONE
  } state_e;
endpackage

@@ rtl/pap_ram.sv @@
// Generic single write, single read RAM with registered read data.
// Standalone; no package dependency.
module pap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/priority_aging_process_scheduler.sv @@
// Top level of the priority aging process scheduler: list walker FSM around
// the process table RAM (pap_ram) and the free map. Uses pap_pkg.
//
// One request at a time. An add walks the ready list to insert; a requeued
// tick walks the lists for ready insert, blocked scan and blocked run. The
// read of the next entry is issued while the current one is compared, and
// each relink is a single RAM write. A result is held in an output
// register; the next request is taken once the FSM is back in idle.
module priority_aging_process_scheduler (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         mode_i,
  input  logic [7:0]   process_id_i,
  input  logic signed [15:0] priority_req_i,
  input  logic [15:0]  total_time_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [2:0]   event_res_o,
  output logic [7:0]   ran_id_o,
  output logic signed [15:0] priority_after_o,
  output logic [15:0]  run_so_far_o,
  output logic         woken_valid_o,
  output logic [7:0]   woken_id_o,
  output logic [6:0]   newly_blocked_o
);
  localparam int unsigned N  = pap_pkg::MAX_PROCESSES;
  localparam int unsigned IW = pap_pkg::IDX_W;
  localparam int unsigned LW = pap_pkg::LINK_W;

  pap_pkg::state_e state_q, state_d;
  logic [LW-1:0] rhead_q, rhead_d, bhead_q, bhead_d;
  logic [N-1:0]  free_q, free_d;
  logic [LW-1:0] walk_q, walk_d, prev_q, prev_d, best_q, best_d, bprev_q, bprev_d;
  logic [LW-1:0] ins_q, ins_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic          tick_q, tick_d;
  pap_pkg::entry_t ce_q, ce_d, pe_q, pe_d, bd_q, bd_d, bpe_q, bpe_d;
  logic [2:0]    ev_q, ev_d;
  logic [7:0]    rid_q, rid_d, wid_q, wid_d;
  logic signed [15:0] pa_q, pa_d;
  logic [15:0]   run_q, run_d;
  logic          wv_q, wv_d;
  logic          ov_q, ov_d;
  logic [2:0]    oev_q, oev_d;
  logic [7:0]    orid_q, orid_d, owid_q, owid_d;
  logic signed [15:0] opa_q, opa_d;
  logic [15:0]   orun_q, orun_d;
  logic          owv_q, owv_d;
  logic [6:0]    onb_q, onb_d;

  logic            we;
  logic [IW-1:0]   waddr, raddr;
  pap_pkg::entry_t wdata, rdata;

  logic            accept, has_free, better;
  logic [IW-1:0]   free_idx;
  logic [15:0]     used_inc, rem_new, rem_best;

  pap_ram #(.WIDTH(pap_pkg::ENTRY_W), .DEPTH(N)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_ready_o = (state_q == pap_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        has_free = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign used_inc = rdata.used + 16'd1;
  assign rem_new  = rdata.need - rdata.used;
  assign rem_best = bd_q.need - bd_q.used;
  assign better   = (rdata.prio > bd_q.prio) ||
                    ((rdata.prio == bd_q.prio) && (rem_new < rem_best));

  always_comb begin
    state_d = state_q;
    case (state_q)
      pap_pkg::ST_IDLE: begin
        if (accept) begin
          if (!mode_i) begin
            state_d = has_free ? pap_pkg::ST_INS_START : pap_pkg::ST_DONE;
          end else begin
            state_d = (rhead_q == pap_pkg::LINK_NONE) ? pap_pkg::ST_DONE : pap_pkg::ST_TK_RD;
          end
        end
      end
      pap_pkg::ST_TK_RD: begin
        state_d = (used_inc == rdata.need) ? pap_pkg::ST_DONE : pap_pkg::ST_INS_START;
      end
      pap_pkg::ST_INS_START: begin
        state_d = (rhead_q == pap_pkg::LINK_NONE) ? pap_pkg::ST_INS_WI : pap_pkg::ST_INS_CMP;
      end
      pap_pkg::ST_INS_CMP: begin
        if ((ce_q.prio > rdata.prio) || (rdata.next == pap_pkg::LINK_NONE)) begin
          state_d = pap_pkg::ST_INS_WI;
        end
      end
      pap_pkg::ST_INS_WI: begin
        if (prev_q != pap_pkg::LINK_NONE) begin
          state_d = pap_pkg::ST_INS_WP;
        end else begin
          state_d = tick_q ? pap_pkg::ST_WK_START : pap_pkg::ST_DONE;
        end
      end
      pap_pkg::ST_INS_WP: begin
        state_d = tick_q ? pap_pkg::ST_WK_START : pap_pkg::ST_DONE;
      end
      pap_pkg::ST_WK_START: begin
        state_d = (bhead_q == pap_pkg::LINK_NONE) ? pap_pkg::ST_BK_START : pap_pkg::ST_WK_CMP;
      end
      pap_pkg::ST_WK_CMP: begin
        if (rdata.next == pap_pkg::LINK_NONE) begin
          state_d = pap_pkg::ST_WK_W1;
        end
      end
      pap_pkg::ST_WK_W1:    state_d = pap_pkg::ST_WK_W2;
      pap_pkg::ST_WK_W2:    state_d = pap_pkg::ST_BK_START;
      pap_pkg::ST_BK_START: state_d = pap_pkg::ST_BK_HEAD;
      pap_pkg::ST_BK_HEAD: begin
        state_d = (rdata.next == pap_pkg::LINK_NONE) ? pap_pkg::ST_DONE : pap_pkg::ST_BK_CMP;
      end
      pap_pkg::ST_BK_CMP: begin
        if (rdata.prio >= bd_q.prio) begin
          if (rdata.next == pap_pkg::LINK_NONE) begin
            state_d = pap_pkg::ST_BK_W1;
          end
        end else begin
          state_d = (cnt_q != '0) ? pap_pkg::ST_BK_W1 : pap_pkg::ST_DONE;
        end
      end
      pap_pkg::ST_BK_W1: state_d = pap_pkg::ST_BK_W2;
      pap_pkg::ST_BK_W2: state_d = pap_pkg::ST_DONE;
      pap_pkg::ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          state_d = pap_pkg::ST_IDLE;
        end
      end
      default: state_d = pap_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rhead_d = rhead_q;  bhead_d = bhead_q;  free_d = free_q;
    walk_d  = walk_q;   prev_d  = prev_q;   best_d = best_q;  bprev_d = bprev_q;
    ins_d   = ins_q;    cnt_d   = cnt_q;    tick_d = tick_q;
    ce_d    = ce_q;     pe_d    = pe_q;     bd_d   = bd_q;    bpe_d   = bpe_q;
    ev_d    = ev_q;     rid_d   = rid_q;    wid_d  = wid_q;   pa_d    = pa_q;
    run_d   = run_q;    wv_d    = wv_q;
    ov_d    = ov_q && !out_ready_i;
    oev_d   = oev_q;    orid_d  = orid_q;   owid_d = owid_q;  opa_d   = opa_q;
    orun_d  = orun_q;   owv_d   = owv_q;    onb_d  = onb_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = ce_q;
    raddr   = rhead_q[IW-1:0];
    case (state_q)
      pap_pkg::ST_IDLE: begin
        if (accept) begin
          ev_d = pap_pkg::EV_ADDED;  rid_d = '0;  wid_d = '0;  pa_d = '0;
          run_d = '0;  wv_d = 1'b0;  cnt_d = '0;  tick_d = mode_i;
          if (!mode_i) begin
            if (!has_free) begin
              ev_d = pap_pkg::EV_REJECTED;
            end else begin
              free_d[free_idx] = 1'b0;
              ins_d = LW'(free_idx);
              ce_d  = '{pid: process_id_i, prio: priority_req_i, need: total_time_i,
                        used: 16'd0, next: pap_pkg::LINK_NONE};
            end
          end else begin
            if (rhead_q == pap_pkg::LINK_NONE) begin
              ev_d = pap_pkg::EV_IDLE;
            end
            ins_d = rhead_q;
          end
        end
      end
      pap_pkg::ST_TK_RD: begin
        rhead_d = rdata.next;
        rid_d   = rdata.pid;
        run_d   = used_inc;
        if (used_inc == rdata.need) begin
          ev_d = pap_pkg::EV_FINISHED;
          pa_d = rdata.prio;
          free_d[ins_q[IW-1:0]] = 1'b1;
        end else begin
          ev_d = pap_pkg::EV_REQUEUED;
          ce_d = rdata;
          ce_d.used = used_inc;
          if (rdata.prio != 16'sh8000) begin
            ce_d.prio = rdata.prio - 16'sd1;
          end
          pa_d = ce_d.prio;
        end
      end
      pap_pkg::ST_INS_START: begin
        walk_d = rhead_q;
        prev_d = pap_pkg::LINK_NONE;
        raddr  = rhead_q[IW-1:0];
      end
      pap_pkg::ST_INS_CMP: begin
        if (!(ce_q.prio > rdata.prio)) begin
          prev_d = walk_q;
          pe_d   = rdata;
          walk_d = rdata.next;
          raddr  = rdata.next[IW-1:0];
        end
      end
      pap_pkg::ST_INS_WI: begin
        we    = 1'b1;
        waddr = ins_q[IW-1:0];
        wdata = ce_q;
        wdata.next = walk_q;
        if (prev_q == pap_pkg::LINK_NONE) begin
          rhead_d = ins_q;
        end
      end
      pap_pkg::ST_INS_WP: begin
        we    = 1'b1;
        waddr = prev_q[IW-1:0];
        wdata = pe_q;
        wdata.next = ins_q;
      end
      pap_pkg::ST_WK_START: begin
        walk_d  = bhead_q;
        prev_d  = pap_pkg::LINK_NONE;
        bprev_d = pap_pkg::LINK_NONE;
        raddr   = bhead_q[IW-1:0];
      end
      pap_pkg::ST_WK_CMP: begin
        if (prev_q == pap_pkg::LINK_NONE) begin
          best_d = walk_q;
          bd_d   = rdata;
        end else if (better) begin
          best_d  = walk_q;
          bd_d    = rdata;
          bprev_d = prev_q;
          bpe_d   = pe_q;
        end
        prev_d = walk_q;
        pe_d   = rdata;
        walk_d = rdata.next;
        raddr  = rdata.next[IW-1:0];
      end
      pap_pkg::ST_WK_W1: begin
        if (bprev_q != pap_pkg::LINK_NONE) begin
          we    = 1'b1;
          waddr = bprev_q[IW-1:0];
          wdata = bpe_q;
          wdata.next = bd_q.next;
        end else begin
          bhead_d = bd_q.next;
        end
      end
      pap_pkg::ST_WK_W2: begin
        we    = 1'b1;
        waddr = best_q[IW-1:0];
        wdata = bd_q;
        wdata.next = rhead_q;
        rhead_d = best_q;
        wv_d    = 1'b1;
        wid_d   = bd_q.pid;
      end
      pap_pkg::ST_BK_START: begin
        raddr = rhead_q[IW-1:0];
      end
      pap_pkg::ST_BK_HEAD: begin
        bd_d   = rdata;
        prev_d = rhead_q;
        pe_d   = rdata;
        walk_d = rdata.next;
        raddr  = rdata.next[IW-1:0];
      end
      pap_pkg::ST_BK_CMP: begin
        if (rdata.prio >= bd_q.prio) begin
          prev_d = walk_q;
          pe_d   = rdata;
          walk_d = rdata.next;
          cnt_d  = cnt_q + LW'(1);
          raddr  = rdata.next[IW-1:0];
        end
      end
      pap_pkg::ST_BK_W1: begin
        we    = 1'b1;
        waddr = prev_q[IW-1:0];
        wdata = pe_q;
        wdata.next = bhead_q;
        bhead_d = bd_q.next;
      end
      pap_pkg::ST_BK_W2: begin
        we    = 1'b1;
        waddr = rhead_q[IW-1:0];
        wdata = bd_q;
        wdata.next = walk_q;
      end
      pap_pkg::ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d   = 1'b1;
          oev_d  = ev_q;
          orid_d = rid_q;
          opa_d  = pa_q;
          orun_d = run_q;
          owv_d  = wv_q;
          owid_d = wid_q;
          onb_d  = 7'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pap_pkg::ST_IDLE;
      rhead_q <= pap_pkg::LINK_NONE;
      bhead_q <= pap_pkg::LINK_NONE;
      free_q  <= '1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rhead_q <= rhead_d;
      bhead_q <= bhead_d;
      free_q  <= free_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q <= walk_d;  prev_q <= prev_d;  best_q <= best_d;  bprev_q <= bprev_d;
    ins_q  <= ins_d;   cnt_q  <= cnt_d;   tick_q <= tick_d;
    ce_q   <= ce_d;    pe_q   <= pe_d;    bd_q   <= bd_d;    bpe_q   <= bpe_d;
    ev_q   <= ev_d;    rid_q  <= rid_d;   wid_q  <= wid_d;   pa_q    <= pa_d;
    run_q  <= run_d;   wv_q   <= wv_d;
    oev_q  <= oev_d;   orid_q <= orid_d;  owid_q <= owid_d;  opa_q   <= opa_d;
    orun_q <= orun_d;  owv_q  <= owv_d;   onb_q  <= onb_d;
  end

  assign out_valid_o      = ov_q;
  assign event_res_o      = oev_q;
  assign ran_id_o         = orid_q;
  assign priority_after_o = opa_q;
  assign run_so_far_o     = orun_q;
  assign woken_valid_o    = owv_q;
  assign woken_id_o       = owid_q;
  assign newly_blocked_o  = onb_q;
endmodule

@@ test/tb.sv @@
// Testbench for priority_aging_process_scheduler: directed and random add and tick requests
// checked against a scoreboard that tracks the ready and blocked lists.
// Depends on pap_pkg and the scheduler RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPROC = int'(pap_pkg::MAX_PROCESSES);
  localparam int NIL = NPROC;
  localparam int N_RANDOM = 1720;
  localparam int WATCH_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic [2:0]         ev;
    logic [7:0]         ran;
    logic signed [15:0] prio;
    logic [15:0]        used;
    logic               wvalid;
    logic [7:0]         wid;
    logic [6:0]         nblk;
  } sched_result_t;

  class sched_scoreboard;
    logic [7:0]  pid  [NPROC];
    int          prio [NPROC];
    logic [15:0] need [NPROC];
    logic [15:0] used [NPROC];
    int          link [NPROC];
    bit          busy [NPROC];
    int          ready_hd;
    int          blocked_hd;
    sched_result_t pending[$];
    int          errors;

    function new();
      for (int i = 0; i < NPROC; i++) begin
        busy[i] = 0;
        link[i] = NIL;
      end
      ready_hd = NIL;
      blocked_hd = NIL;
      errors = 0;
    endfunction

    function void insert_ready(int i);
      int prv, cur, g;
      if (ready_hd == NIL || prio[i] > prio[ready_hd]) begin
        link[i] = ready_hd;
        ready_hd = i;
        return;
      end
      prv = ready_hd;
      cur = link[prv];
      g = 0;
      while (cur != NIL && g < NPROC && !(prio[i] > prio[cur])) begin
        prv = cur;
        cur = link[cur];
        g++;
      end
      link[i] = cur;
      link[prv] = i;
    endfunction

    function int wake_best();
      int best, best_prv, prv, cur, g;
      logic [15:0] rc, rb;
      if (blocked_hd == NIL) return NIL;
      best = blocked_hd;
      best_prv = NIL;
      prv = blocked_hd;
      cur = link[blocked_hd];
      g = 0;
      while (cur != NIL && g < NPROC) begin
        rc = need[cur] - used[cur];
        rb = need[best] - used[best];
        if (prio[cur] > prio[best] || (prio[cur] == prio[best] && rc < rb)) begin
          best = cur;
          best_prv = prv;
        end
        prv = cur;
        cur = link[cur];
        g++;
      end
      if (best_prv != NIL) link[best_prv] = link[best];
      else blocked_hd = link[best];
      link[best] = ready_hd;
      ready_hd = best;
      return best;
    endfunction

    function int block_run();
      int h, last, nx, cnt, first;
      h = ready_hd;
      if (h == NIL) return 0;
      last = h;
      nx = link[last];
      cnt = 0;
      while (nx != NIL && cnt < NPROC && prio[nx] >= prio[h]) begin
        last = nx;
        nx = link[last];
        cnt++;
      end
      if (cnt > 0) begin
        first = link[h];
        link[last] = blocked_hd;
        blocked_hd = first;
        link[h] = nx;
      end
      return cnt;
    endfunction

    function void note_request(logic m, logic [7:0] id, logic signed [15:0] pr,
                               logic [15:0] tt);
      sched_result_t r;
      int slot, cur, w;
      r = '0;
      if (!m) begin
        slot = NIL;
        for (int i = NPROC - 1; i >= 0; i--) if (!busy[i]) slot = i;
        if (slot == NIL) begin
          r.ev = pap_pkg::EV_REJECTED;
        end else begin
          busy[slot] = 1;
          pid[slot] = id;
          prio[slot] = int'(pr);
          need[slot] = tt;
          used[slot] = '0;
          link[slot] = NIL;
          insert_ready(slot);
          r.ev = pap_pkg::EV_ADDED;
        end
      end else if (ready_hd == NIL) begin
        r.ev = pap_pkg::EV_IDLE;
      end else begin
        cur = ready_hd;
        ready_hd = link[cur];
        link[cur] = NIL;
        used[cur] = used[cur] + 16'd1;
        r.ran = pid[cur];
        r.used = used[cur];
        if (used[cur] == need[cur]) begin
          r.ev = pap_pkg::EV_FINISHED;
          r.prio = 16'(prio[cur]);
          busy[cur] = 0;
        end else begin
          if (prio[cur] > -32768) prio[cur]--;
          r.ev = pap_pkg::EV_REQUEUED;
          r.prio = 16'(prio[cur]);
          insert_ready(cur);
          w = wake_best();
          if (w != NIL) begin
            r.wvalid = 1'b1;
            r.wid = pid[w];
          end
          r.nblk = 7'(block_run());
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(sched_result_t a);
      sched_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result event_res=%0d", a.ev);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.ev !== e.ev) begin
        $error("event_res expected %0d actual %0d", e.ev, a.ev); errors++;
      end
      if (a.ran !== e.ran) begin
        $error("ran_id expected %0d actual %0d", e.ran, a.ran); errors++;
      end
      if (a.prio !== e.prio) begin
        $error("priority_after expected %0d actual %0d", e.prio, a.prio); errors++;
      end
      if (a.used !== e.used) begin
        $error("run_so_far expected %0d actual %0d", e.used, a.used); errors++;
      end
      if (a.wvalid !== e.wvalid) begin
        $error("woken_valid expected %0d actual %0d", e.wvalid, a.wvalid); errors++;
      end
      if (a.wid !== e.wid) begin
        $error("woken_id expected %0d actual %0d", e.wid, a.wid); errors++;
      end
      if (a.nblk !== e.nblk) begin
        $error("newly_blocked expected %0d actual %0d", e.nblk, a.nblk); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = 1'b0;
  logic [7:0] process_id_i = '0;
  logic signed [15:0] priority_req_i = '0;
  logic [15:0] total_time_i = 16'd1;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] event_res_o;
  logic [7:0] ran_id_o;
  logic signed [15:0] priority_after_o;
  logic [15:0] run_so_far_o;
  logic woken_valid_o;
  logic [7:0] woken_id_o;
  logic [6:0] newly_blocked_o;

  sched_scoreboard sb;
  int idle_cycles = 0;
  int results_seen = 0;
  bit hold_done = 0;

  priority_aging_process_scheduler uut (.*);

  always #1 clk_i = ~clk_i;

  task automatic send_request(logic m, logic [7:0] id, logic signed [15:0] pr,
                              logic [15:0] tt);
    int gap;
    gap = $urandom_range(13);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i = m;
    process_id_i = id;
    priority_req_i = pr;
    total_time_i = tt;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(m, id, pr, tt);
    @(negedge clk_i);
  endtask

  task automatic send_add(logic [7:0] id, logic signed [15:0] pr, logic [15:0] tt);
    send_request(1'b0, id, pr, tt);
  endtask

  task automatic send_tick();
    send_request(1'b1, 8'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)));
  endtask

  task automatic send_random();
    logic signed [15:0] pr;
    logic [15:0] tt;
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) pr = 16'($signed($urandom_range(6)) - 3);
    else if (sel < 85) pr = 16'sh7fff - 16'($urandom_range(1));
    else if (sel < 90) pr = -16'sh8000 + 16'($urandom_range(1));
    else pr = 16'($urandom);
    sel = $urandom_range(99);
    if (sel < 70) tt = 16'($urandom_range(8, 1));
    else if (sel < 95) tt = 16'($urandom_range(64, 1));
    else tt = 16'($urandom_range(65535, 1));
    if ($urandom_range(99) < 45) send_add(8'($urandom), pr, tt);
    else send_tick();
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_tick();
    send_add(8'd255, -16'sh8000, 16'd1);
    send_tick();
    send_add(8'd1, -16'sh8000, 16'd3);
    send_add(8'd0, 16'sh7fff, 16'd65535);
    send_tick();
    send_tick();
    send_tick();
    for (int i = 0; i < 17; i++) send_add(8'(i + 16), 16'($signed(i % 4) - 1), 16'(i % 3 + 1));
    repeat (4) send_tick();
    for (int i = 0; i < N_RANDOM; i++) send_random();
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen == 300) begin
        hold_done = 1;
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if ($urandom_range(3) != 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(13)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      sb.check_result({event_res_o, ran_id_o, priority_after_o, run_so_far_o,
                       woken_valid_o, woken_id_o, newly_blocked_o});
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end
endmodule
